// File: design/abrs_pkg.sv
package abrs_pkg;

   // default coordinate width, Q8.8 signed
   localparam int COORD_BITS_DEF = 16;

   // slab distances are signed Q16.16
   localparam int T_BITS = 32;
   localparam int T_FRAC = 16;

   typedef logic signed [T_BITS-1:0] t_type;

   localparam t_type T_MAX = {1'b0, {(T_BITS-1){1'b1}}};
   localparam t_type T_MIN = {1'b1, {(T_BITS-1){1'b0}}};

   typedef struct packed {
      logic done;
      logic hit;
   } eval_stat_type;

endpackage

// File: design/aabb_build_and_ray_slab_test_top.sv
// channel   dir  handshake                  payload
// req       in   req_tvalid / req_tready    tuser: action; tdata: pos_x..z, dir_x..z
// rsp       out  rsp_tvalid / rsp_tready    tdata: hit
//
// Add point: box registers update at the accepting edge.
// Ray test: six restoring dividers run side by side, one quotient bit per cycle,
// then a four-stage compare.
// Empty box or zero direction outside its slab: miss, without running the dividers.
// Reset is synchronous and leaves the box empty; no clearing pass.
// The result register holds a beat until taken; items are accepted only while idle,
// also when it is full; a finished ray test waits while it is full and not taken.
module aabb_build_and_ray_slab_test_top #(
   parameter int COORD_BITS = abrs_pkg::COORD_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, zero pad
   input  logic [((6*COORD_BITS+7)/8)*8-1:0]     req_tdata,
   // action
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // hit, zero pad
   output logic [7:0]                            rsp_tdata
);
   import abrs_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_EVAL = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [2:0] zero_ff, zero_in;
   logic       hit_ff, hit_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_hit_ff, rsp_hit_in;

   logic signed [COORD_BITS-1:0] pos [3];
   logic signed [COORD_BITS-1:0] dir [3];
   logic signed [COORD_BITS-1:0] box_min [3];
   logic signed [COORD_BITS-1:0] box_max [3];
   logic        empty;
   logic        acc;
   logic        ray;
   logic        lane_start;
   logic        eval_start;
   logic [2:0]  zero_now;
   logic [2:0]  out_slab;
   logic [5:0]  lane_done;
   t_type       t_val [6];
   eval_stat_type stat;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pos[i] = req_tdata[i*COORD_BITS +: COORD_BITS];
         dir[i] = req_tdata[(3+i)*COORD_BITS +: COORD_BITS];
         zero_now[i] = (dir[i] == '0);
         out_slab[i] = (pos[i] < box_min[i]) || (pos[i] > box_max[i]);
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign acc        = req_tvalid && req_tready;
   assign ray        = req_tuser;

   always_comb begin
      state_in     = state_ff;
      zero_in      = zero_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_hit_in   = rsp_hit_ff;
      lane_start   = 1'b0;
      eval_start   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (acc && ray) begin
               zero_in = zero_now;
               if (empty || ((zero_now & out_slab) != 3'b000)) begin
                  hit_in   = 1'b0;
                  state_in = ST_FIN;
               end else begin
                  lane_start = 1'b1;
                  state_in   = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (&lane_done) begin
               eval_start = 1'b1;
               state_in   = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (stat.done) begin
               hit_in   = stat.hit;
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = hit_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      zero_ff    <= zero_in;
      hit_ff     <= hit_in;
      rsp_hit_ff <= rsp_hit_in;
   end

   abrs_box #(
      .COORD_BITS(COORD_BITS)
   ) u_box (
      .clock   (clock),
      .reset   (reset),
      .upd     (acc && !ray),
      .pnt     (pos),
      .box_min (box_min),
      .box_max (box_max),
      .empty   (empty)
   );

   for (genvar g = 0; g < 6; g++) begin : g_lane
      abrs_div_lane #(
         .COORD_BITS(COORD_BITS)
      ) u_lane (
         .clock (clock),
         .reset (reset),
         .start (lane_start),
         .bound ((g % 2 == 1) ? box_max[g/2] : box_min[g/2]),
         .org   (pos[g/2]),
         .dir   (dir[g/2]),
         .t_val (t_val[g]),
         .done  (lane_done[g])
      );
   end

   abrs_slab_eval u_eval (
      .clock    (clock),
      .reset    (reset),
      .start    (eval_start),
      .t_val    (t_val),
      .zero_dir (zero_ff),
      .stat     (stat)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0000000, rsp_hit_ff};

endmodule

// File: design/abrs_box.sv
module abrs_box #(
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         upd,
   input  logic signed [COORD_BITS-1:0] pnt [3],
   output logic signed [COORD_BITS-1:0] box_min [3],
   output logic signed [COORD_BITS-1:0] box_max [3],
   output logic                         empty
);
   import abrs_pkg::*;

   localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   logic signed [COORD_BITS-1:0] min_ff [3];
   logic signed [COORD_BITS-1:0] max_ff [3];
   logic signed [COORD_BITS-1:0] min_in [3];
   logic signed [COORD_BITS-1:0] max_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         min_in[i] = min_ff[i];
         max_in[i] = max_ff[i];
         if (upd) begin
            if (pnt[i] < min_ff[i]) min_in[i] = pnt[i];
            if (pnt[i] > max_ff[i]) max_in[i] = pnt[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (reset) begin
            min_ff[i] <= C_MAX;
            max_ff[i] <= C_MIN;
         end else begin
            min_ff[i] <= min_in[i];
            max_ff[i] <= max_in[i];
         end
      end
   end

   assign box_min = min_ff;
   assign box_max = max_ff;
   assign empty   = (min_ff[0] > max_ff[0]) || (min_ff[1] > max_ff[1]) ||
                    (min_ff[2] > max_ff[2]);

endmodule

// File: design/abrs_div_lane.sv
module abrs_div_lane #(
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [COORD_BITS-1:0] bound,
   input  logic signed [COORD_BITS-1:0] org,
   input  logic signed [COORD_BITS-1:0] dir,
   output abrs_pkg::t_type              t_val,
   output logic                         done
);
   import abrs_pkg::*;

   localparam int QW = COORD_BITS + T_FRAC;
   localparam int CW = $clog2(QW + 1);
   localparam int WW = (QW >= T_BITS) ? QW + 1 : T_BITS + 1;

   localparam logic signed [WW-1:0] W_MAX = {{(WW-T_BITS){1'b0}}, T_MAX};
   localparam logic signed [WW-1:0] W_MIN = {{(WW-T_BITS){1'b1}}, T_MIN};

   logic [QW-1:0]         num_ff, num_in;
   logic [QW-1:0]         q_ff, q_in;
   logic [COORD_BITS-1:0] rem_ff, rem_in;
   logic [COORD_BITS-1:0] dmag_ff, dmag_in;
   logic                  neg_ff, neg_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  sat_ff, sat_in;
   logic                  done_ff, done_in;
   t_type                 t_ff, t_in;

   logic signed [COORD_BITS:0] diff;
   logic [COORD_BITS:0]        diff_mag;
   logic [COORD_BITS:0]        trial;
   logic [COORD_BITS:0]        trial_sub;
   logic                       ge;
   logic signed [WW-1:0]       q_ext;
   logic signed [WW-1:0]       q_sgn;

   always_comb begin
      diff     = {bound[COORD_BITS-1], bound} - {org[COORD_BITS-1], org};
      diff_mag = diff[COORD_BITS] ? (~diff + 1'b1) : diff;

      // restoring step: one quotient bit per cycle
      trial     = {rem_ff, num_ff[QW-1]};
      trial_sub = trial - {1'b0, dmag_ff};
      ge        = !trial_sub[COORD_BITS];

      q_ext = $signed({{(WW-QW){1'b0}}, q_ff});
      q_sgn = neg_ff ? -q_ext : q_ext;

      num_in  = num_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      dmag_in = dmag_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      sat_in  = 1'b0;
      done_in = done_ff;
      t_in    = t_ff;

      if (start) begin
         num_in  = {diff_mag[COORD_BITS-1:0], {T_FRAC{1'b0}}};
         q_in    = '0;
         rem_in  = '0;
         dmag_in = dir[COORD_BITS-1] ? (~dir + 1'b1) : dir;
         neg_in  = diff[COORD_BITS] ^ dir[COORD_BITS-1];
         cnt_in  = CW'(QW);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         num_in = {num_ff[QW-2:0], 1'b0};
         q_in   = {q_ff[QW-2:0], ge};
         rem_in = ge ? trial_sub[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            sat_in  = 1'b1;
         end
      end else if (sat_ff) begin
         if (q_sgn > W_MAX)      t_in = T_MAX;
         else if (q_sgn < W_MIN) t_in = T_MIN;
         else                    t_in = q_sgn[T_BITS-1:0];
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         sat_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         sat_ff  <= sat_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff  <= num_in;
      q_ff    <= q_in;
      rem_ff  <= rem_in;
      dmag_ff <= dmag_in;
      neg_ff  <= neg_in;
      t_ff    <= t_in;
   end

   assign t_val = t_ff;
   assign done  = done_ff;

endmodule

// File: design/abrs_slab_eval.sv
module abrs_slab_eval (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  abrs_pkg::t_type        t_val [6],
   input  logic [2:0]             zero_dir,
   output abrs_pkg::eval_stat_type stat
);
   import abrs_pkg::*;

   // t_val order: axis * 2 + (0 = min bound, 1 = max bound)
   t_type lo1_ff [3];
   t_type hi1_ff [3];
   t_type lo1_in [3];
   t_type hi1_in [3];
   t_type lo2_ff, hi2_ff, clo2_ff, chi2_ff;
   t_type lo3_ff, hi3_ff;
   logic  hit_ff;
   logic [3:0] vld_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (zero_dir[i]) begin
            lo1_in[i] = T_MIN;
            hi1_in[i] = T_MAX;
         end else if (t_val[2*i] > t_val[2*i+1]) begin
            lo1_in[i] = t_val[2*i+1];
            hi1_in[i] = t_val[2*i];
         end else begin
            lo1_in[i] = t_val[2*i];
            hi1_in[i] = t_val[2*i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[2:0], start};
      end
      lo1_ff  <= lo1_in;
      hi1_ff  <= hi1_in;
      lo2_ff  <= (lo1_ff[1] > lo1_ff[0]) ? lo1_ff[1] : lo1_ff[0];
      hi2_ff  <= (hi1_ff[1] < hi1_ff[0]) ? hi1_ff[1] : hi1_ff[0];
      clo2_ff <= lo1_ff[2];
      chi2_ff <= hi1_ff[2];
      lo3_ff  <= (clo2_ff > lo2_ff) ? clo2_ff : lo2_ff;
      hi3_ff  <= (chi2_ff < hi2_ff) ? chi2_ff : hi2_ff;
      // touching intervals still count
      hit_ff  <= (lo3_ff <= hi3_ff);
   end

   assign stat.done = vld_ff[3];
   assign stat.hit  = hit_ff;

endmodule
